/* hdl/sdls_pkg.sv */
// Shared types and constants for the split dual LFSR sequencer.
// Used by every module in this folder; depends on nothing else.
package sdls_pkg;

    // Default register length of the combined sequence
    localparam int REGISTER_BITS_DEF = 16;

    // Depth of the step queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Field widths
    localparam int TAP_BITS   = 16;
    localparam int SPLIT_BITS = 5;
    localparam int OUT_BITS   = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 72;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_WORD    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPLIT_POINT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_XNOR_FIRST  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_XNOR_SECOND = 2'd3;

    // Reset values of the configuration registers
    localparam logic [TAP_BITS-1:0]   TAP_WORD_RST    = 16'd0;
    localparam logic [SPLIT_BITS-1:0] SPLIT_POINT_RST = 5'd16;

    // Configuration as seen by the back end
    typedef struct packed {
        logic [TAP_BITS-1:0]   tap_word;
        logic [SPLIT_BITS-1:0] split_point;
        logic                  xnor_first;
        logic                  xnor_second;
    } t_cfg;

    // One step command travelling through the queue
    typedef struct packed {
        logic advance_second;
        logic advance_first;
    } t_step;

    // Result word
    typedef struct packed {
        logic [3:0]          column_parity;
        logic [3:0]          row_parity;
        logic [OUT_BITS-1:0] column_word;
        logic [OUT_BITS-1:0] grid_word;
        logic [OUT_BITS-1:0] second_value;
        logic [OUT_BITS-1:0] first_value;
    } t_result;

endpackage

/* hdl/split_dual_lfsr_sequencer.sv */
// Top level of the split dual LFSR sequencer: configuration registers,
// front end, step queue and back end. Depends on sdls_pkg and the sdls_* modules.
//
//  Channel | Direction | Ports                              | Word
//  input   | in        | i_s_tvalid/o_s_tready/i_s_tdata    | [0] advance_first, [1] advance_second
//  output  | out       | o_m_tvalid/i_m_tready/o_m_tdata    | one result per useful input word
//  config  | in        | i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data | register write
//
// One input word is taken every cycle while o_s_tready is high; the back end steps
// both sequences together, so a result can leave every cycle while i_m_tready is high.
// A step passes through the front holding register, the queue and the output register.
// Reset is synchronous and active low; both sequences restart at one.
// A stalled output fills the queue, then the front, then drops o_s_tready.
module split_dual_lfsr_sequencer #(
    parameter int REGISTER_BITS = sdls_pkg::REGISTER_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: [0] advance_first, [1] advance_second, [7:2] zero
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [sdls_pkg::IN_TDATA_BITS-1:0]   i_s_tdata,
    // tdata: [15:0] first_value, [31:16] second_value, [47:32] grid_word,
    //        [63:48] column_word, [67:64] row_parity, [71:68] column_parity
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [sdls_pkg::OUT_TDATA_BITS-1:0]  o_m_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sdls_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [sdls_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import sdls_pkg::*;

    t_cfg  r_cfg;
    logic  push;
    logic  pop;
    logic  q_ready;
    logic  q_valid;
    t_step front_step;
    t_step queue_step;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_word    <= TAP_WORD_RST;
            r_cfg.split_point <= SPLIT_POINT_RST;
            r_cfg.xnor_first  <= 1'b0;
            r_cfg.xnor_second <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TAP_WORD: begin
                    r_cfg.tap_word <= i_cfg_data[TAP_BITS-1:0];
                end
                CFG_SPLIT_POINT: begin
                    r_cfg.split_point <= i_cfg_data[SPLIT_BITS-1:0];
                end
                CFG_XNOR_FIRST: begin
                    r_cfg.xnor_first <= i_cfg_data[0];
                end
                CFG_XNOR_SECOND: begin
                    r_cfg.xnor_second <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end
    sdls_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_push     (push),
        .o_step     (front_step),
        .i_q_ready  (q_ready)
    );

    // Step queue
    sdls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_step  (front_step),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_step  (queue_step),
        .i_pop   (pop)
    );

    // Back end
    sdls_back #(
        .REGISTER_BITS (REGISTER_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_step     (queue_step),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

/* hdl/sdls_front.sv */
// Front end: takes input words, drops those that advance nothing and
// holds the rest for the step queue. Depends on sdls_pkg.
module sdls_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [sdls_pkg::IN_TDATA_BITS-1:0] i_s_tdata,
    output logic                              o_push,
    output sdls_pkg::t_step                   o_step,
    input  logic                              i_q_ready
);
    import sdls_pkg::*;

    logic  r_valid;
    t_step r_step;
    t_step n_step;
    logic  accept;
    logic  useful;

    // Decode the incoming word: bit 0 steps the first sequence, bit 1 the second.
    assign n_step.advance_first  = i_s_tdata[0];
    assign n_step.advance_second = i_s_tdata[1];
    assign useful = n_step.advance_first | n_step.advance_second;

    assign o_push     = r_valid & i_q_ready;
    assign o_s_tready = ~r_valid | i_q_ready;
    assign accept     = i_s_tvalid & o_s_tready;
    assign o_step     = r_step;

    // Holding register; a word with no advance is taken and discarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= useful;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_step <= n_step;
        end
    end

endmodule

/* hdl/sdls_queue.sv */
// Short step queue that decouples the front end from the back end.
// Depends on sdls_pkg for the entry type and depth.
module sdls_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sdls_pkg::t_step i_step,
    output logic            o_ready,
    output logic            o_valid,
    output sdls_pkg::t_step o_step,
    input  logic            i_pop
);
    import sdls_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_step               r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    assign o_ready = (r_count != CNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_step  = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_step;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/sdls_back.sv */
// Back end: steps both LFSRs, forms the grid view and holds the result word.
// Depends on sdls_pkg for the configuration, step and result types.
module sdls_back #(
    parameter int REGISTER_BITS = sdls_pkg::REGISTER_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sdls_pkg::t_cfg                      i_cfg,
    input  logic                                i_q_valid,
    input  sdls_pkg::t_step                     i_step,
    output logic                                o_pop,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [sdls_pkg::OUT_TDATA_BITS-1:0] o_m_tdata
);
    import sdls_pkg::*;

    localparam int RB  = REGISTER_BITS;
    localparam int SW  = $clog2(RB + 1);
    localparam int CW  = (SW > SPLIT_BITS) ? SW : SPLIT_BITS;
    localparam int WW  = (RB > OUT_BITS) ? RB : OUT_BITS;
    localparam int TWW = (RB > TAP_BITS) ? RB : TAP_BITS;

    logic [RB-1:0] r_first;
    logic [RB-1:0] r_second;
    logic          r_out_valid;
    t_result       r_result;

    logic [SW-1:0]  split;
    logic [SW-1:0]  len_second;
    logic [TWW-1:0] tap_ext;
    logic [RB-1:0]  taps_first;
    logic [RB-1:0]  taps_second;
    logic [RB:0]    mask_first_w;
    logic [RB:0]    mask_second_w;
    logic [RB-1:0]  mask_first;
    logic [RB-1:0]  mask_second;
    logic           fb_first;
    logic           fb_second;
    logic [RB-1:0]  n_first;
    logic [RB-1:0]  n_second;
    logic [WW-1:0]  first_ext;
    logic [WW-1:0]  second_ext;
    logic [WW-1:0]  second_shift;
    logic [OUT_BITS-1:0] grid;
    t_result        n_result;

    assign o_pop = i_q_valid & (~r_out_valid | i_m_tready);

    // Clamp the split point to the register length.
    always_comb begin
        if (CW'(i_cfg.split_point) > CW'(RB)) begin
            split = SW'(RB);
        end else begin
            split = SW'(i_cfg.split_point);
        end
    end
    assign len_second = SW'(RB) - split;

    // Tap bits above the register are ignored; the second sequence uses the upper part.
    assign tap_ext     = TWW'(i_cfg.tap_word);
    assign taps_first  = tap_ext[RB-1:0];
    assign taps_second = taps_first >> split;

    // Length masks; a length of zero gives an all-zero mask.
    assign mask_first_w  = ((RB + 1)'(1) << split) - 1'b1;
    assign mask_second_w = ((RB + 1)'(1) << len_second) - 1'b1;
    assign mask_first    = mask_first_w[RB-1:0];
    assign mask_second   = mask_second_w[RB-1:0];

    // Feedback parity and shift for each sequence.
    assign fb_first  = (^(taps_first & mask_first & r_first)) ^ i_cfg.xnor_first;
    assign fb_second = (^(taps_second & mask_second & r_second)) ^ i_cfg.xnor_second;

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        if (i_step.advance_first) begin
            n_first = {r_first[RB-2:0], fb_first} & mask_first;
        end
        if (i_step.advance_second) begin
            n_second = {r_second[RB-2:0], fb_second} & mask_second;
        end
    end

    // Combined word, its column transpose and the parities.
    assign first_ext    = WW'(n_first);
    assign second_ext   = WW'(n_second);
    assign second_shift = second_ext << split;
    assign grid         = second_shift[OUT_BITS-1:0] + first_ext[OUT_BITS-1:0];

    always_comb begin
        n_result.first_value  = first_ext[OUT_BITS-1:0];
        n_result.second_value = second_ext[OUT_BITS-1:0];
        n_result.grid_word    = grid;
        for (int i = 0; i < 4; i++) begin
            n_result.column_word[4*i +: 4] = {grid[i+12], grid[i+8], grid[i+4], grid[i]};
            n_result.row_parity[i]         = ^grid[4*i +: 4];
            n_result.column_parity[i]      = grid[i] ^ grid[i+4] ^ grid[i+8] ^ grid[i+12];
        end
    end

    // Sequence state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= RB'(1);
            r_second    <= RB'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_first     <= n_first;
                r_second    <= n_second;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_result;

    // A step taken from the queue always shows up as a result next cycle.
    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("step popped without a result");

    // While a result is stalled, neither sequence may move.
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> ($stable(r_first) && $stable(r_second)))
        else $error("sequence moved under a stalled result");

    // The grid row parities always agree with the grid word held.
    a_row_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (^r_result.row_parity == ^r_result.grid_word))
        else $error("row parity disagrees with grid word");

endmodule
